[design/pse_pkg.sv]
`timescale 1ns / 1ps

package pse_pkg;

    localparam int TABLE_SIZE_DEFAULT = 65536;
    localparam int LIMIT_W            = 16;
    localparam int VALUE_W            = 16;
    localparam int COUNT_W            = 17;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd100;

endpackage

[design/pse_ram.sv]
`timescale 1ns / 1ps

module pse_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = pse_pkg::TABLE_SIZE_DEFAULT
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/pse_alu.sv]
`timescale 1ns / 1ps

module pse_alu #(
    parameter int W = 18
) (
    input  logic [W-1:0] opa,
    input  logic [W-1:0] opb,
    input  logic [W-1:0] lim,
    output logic [W-1:0] sum,
    output logic         le
);

    // shared adder and limit compare
    assign sum = opa + opb;
    assign le  = (opa <= lim);

endmodule

[design/prime_sieve_engine_unit.sv]
`timescale 1ns / 1ps
// scan: each table entry is read from the registered mark memory (S_SCAN, S_SCAN_RD),
//   result registered; an exhausted scan ends in a final compare in S_SCAN
// rebuild clears marks 2..limit (S_CLEAR), then for each i with i*i <= limit reads its mark,
//   strikes multiples from i*i if unmarked (S_STRIKE), steps i (S_NEXT), then starts the scan
// throughput: one request at a time, next start taken once busy falls; receiver cannot stall
// reset: control state cleared, upper_limit 100, mark memory undefined, first request rebuilds
module prime_sieve_engine_unit #(
    parameter int TABLE_SIZE = pse_pkg::TABLE_SIZE_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         restart,
    input  logic                         upper_limit_we,
    input  logic [pse_pkg::LIMIT_W-1:0]  upper_limit,
    output logic                         result_valid,
    output logic [pse_pkg::VALUE_W-1:0]  prime_value,
    output logic [pse_pkg::VALUE_W-1:0]  prime_ordinal,
    output logic                         exhausted
);

    localparam int AW = $clog2(TABLE_SIZE);
    localparam int CW = AW + 1;
    localparam int W  = CW + 1;
    localparam int EW = (CW > pse_pkg::LIMIT_W) ? CW : pse_pkg::LIMIT_W;
    localparam logic [EW-1:0] MAX_LIM = EW'(TABLE_SIZE - 1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_CLEAR    = 3'd1;
    localparam logic [2:0] S_OUTER    = 3'd2;
    localparam logic [2:0] S_OUTER_RD = 3'd3;
    localparam logic [2:0] S_STRIKE   = 3'd4;
    localparam logic [2:0] S_NEXT     = 3'd5;
    localparam logic [2:0] S_SCAN     = 3'd6;
    localparam logic [2:0] S_SCAN_RD  = 3'd7;

    logic [2:0]                    state_reg, state_next;
    logic [pse_pkg::LIMIT_W-1:0]   limit_reg;
    logic                          built_reg, built_next;
    logic [CW-1:0]                 i_reg, i_next;
    logic [CW-1:0]                 j_reg, j_next;
    logic [W-1:0]                  sq_reg, sq_next;
    logic [CW-1:0]                 cursor_reg, cursor_next;
    logic [pse_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic                          res_valid_reg, res_valid_next;
    logic [pse_pkg::VALUE_W-1:0]   value_reg, value_next;
    logic [pse_pkg::VALUE_W-1:0]   ordinal_reg, ordinal_next;
    logic                          exh_reg, exh_next;

    logic [EW-1:0] lim_wide;
    logic [CW-1:0] eff_lim;
    logic [W-1:0]  opa, opb, alu_sum;
    logic          alu_le;
    logic          ram_we, ram_wdata, ram_rdata;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [pse_pkg::COUNT_W-1:0] count_inc;

    assign lim_wide = EW'(limit_reg);
    assign eff_lim  = (lim_wide > MAX_LIM) ? CW'(MAX_LIM) : CW'(lim_wide);
    assign count_inc = count_reg + 1'b1;

    pse_alu #(.W(W)) u_alu (
        .opa (opa),
        .opb (opb),
        .lim (W'(eff_lim)),
        .sum (alu_sum),
        .le  (alu_le)
    );

    pse_ram #(.WIDTH(1), .DEPTH(TABLE_SIZE)) u_marks (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        opa = '0;
        opb = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                opa = W'(i_reg);
                opb = W'(1);
            end
            S_OUTER:
            begin
                opa = sq_reg;
            end
            S_STRIKE:
            begin
                opa = W'(j_reg);
                opb = W'(i_reg);
            end
            S_NEXT:
            begin
                opa = sq_reg;
                opb = {i_reg, 1'b1};
            end
            S_SCAN:
            begin
                opa = W'(cursor_reg);
            end
            S_SCAN_RD:
            begin
                opa = W'(cursor_reg);
                opb = W'(1);
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        built_next     = built_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        sq_next        = sq_reg;
        cursor_next    = cursor_reg;
        count_next     = count_reg;
        res_valid_next = 1'b0;
        value_next     = value_reg;
        ordinal_next   = ordinal_reg;
        exh_next       = exh_reg;
        ram_we         = 1'b0;
        ram_wdata      = 1'b0;
        ram_waddr      = i_reg[AW-1:0];
        ram_raddr      = i_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (restart || !built_reg)
                    begin
                        i_next     = CW'(2);
                        state_next = S_CLEAR;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_CLEAR:
            begin
                if (alu_le)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = 1'b0;
                    i_next    = alu_sum[CW-1:0];
                end
                else
                begin
                    i_next     = CW'(2);
                    sq_next    = W'(4);
                    state_next = S_OUTER;
                end
            end
            S_OUTER:
            begin
                if (alu_le)
                begin
                    state_next = S_OUTER_RD;
                end
                else
                begin
                    cursor_next = CW'(2);
                    count_next  = '0;
                    built_next  = 1'b1;
                    state_next  = S_SCAN;
                end
            end
            S_OUTER_RD:
            begin
                if (ram_rdata)
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    j_next     = sq_reg[CW-1:0];
                    state_next = S_STRIKE;
                end
            end
            S_STRIKE:
            begin
                ram_waddr = j_reg[AW-1:0];
                if (alu_le)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = 1'b1;
                    j_next    = alu_sum[CW-1:0];
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                sq_next    = alu_sum;
                i_next     = i_reg + 1'b1;
                state_next = S_OUTER;
            end
            S_SCAN:
            begin
                ram_raddr = cursor_reg[AW-1:0];
                if (alu_le)
                begin
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    res_valid_next = 1'b1;
                    value_next     = '0;
                    ordinal_next   = count_reg[pse_pkg::VALUE_W-1:0];
                    exh_next       = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_SCAN_RD:
            begin
                ram_raddr   = cursor_reg[AW-1:0];
                cursor_next = alu_sum[CW-1:0];
                if (ram_rdata)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    count_next     = count_inc;
                    res_valid_next = 1'b1;
                    value_next     = pse_pkg::VALUE_W'(cursor_reg);
                    ordinal_next   = count_inc[pse_pkg::VALUE_W-1:0];
                    exh_next       = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // limit change forces a rebuild on the next transfer
        if (upper_limit_we)
        begin
            built_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            limit_reg     <= pse_pkg::LIMIT_RESET;
            built_reg     <= 1'b0;
            cursor_reg    <= CW'(2);
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            built_reg     <= built_next;
            cursor_reg    <= cursor_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
            if (upper_limit_we)
            begin
                limit_reg <= upper_limit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg       <= i_next;
        j_reg       <= j_next;
        sq_reg      <= sq_next;
        value_reg   <= value_next;
        ordinal_reg <= ordinal_next;
        exh_reg     <= exh_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign result_valid  = res_valid_reg;
    assign prime_value   = value_reg;
    assign prime_ordinal = ordinal_reg;
    assign exhausted     = exh_reg;

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transfer did not raise busy");

    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result while still busy");

    a_result_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ($past(state_reg) == S_SCAN || $past(state_reg) == S_SCAN_RD))
        else $error("result not produced by the scan");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_CLEAR || state_reg == S_STRIKE))
        else $error("mark write outside clear or strike");

    a_exhausted_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && exhausted) |-> (prime_value == '0))
        else $error("exhausted result carries a value");
`endif

endmodule
